>>> rtl/mqttd_pkg.sv
// ----------------------------------------------------------------------------
// MQTT deframer package
// Phase codes, status codes and the state and result records of the deframer.
// ----------------------------------------------------------------------------
package mqttd_pkg;

  localparam int unsigned LenW    = 28;
  localparam int unsigned OffW    = 29;
  localparam logic [LenW-1:0] MaxLenReset = 28'd1024;
  localparam logic [7:0] ContBit = 8'h80;

  typedef enum logic [2:0] {
    PH_TYPE = 3'd0,
    PH_LEN0 = 3'd1,
    PH_LEN1 = 3'd2,
    PH_LEN2 = 3'd3,
    PH_LEN3 = 3'd4,
    PH_DATA = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_PROGRESS  = 2'd0,
    ST_COMPLETE  = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_t;

  typedef struct packed {
    phase_t            phase;
    logic [LenW-1:0]   length_accum;
    logic [LenW-1:0]   data_left;
    logic [OffW-1:0]   write_offset;
  } frame_state_t;

  typedef struct packed {
    logic [7:0]        byte_value;
    logic [OffW-1:0]   byte_offset;
    logic              packet_start;
    status_t           status;
    logic [OffW-1:0]   packet_length;
  } frame_result_t;

endpackage

>>> rtl/mqttd_step.sv
// ----------------------------------------------------------------------------
// MQTT deframer step
// Next frame state and the result for one received byte.
// ----------------------------------------------------------------------------
module mqttd_step import mqttd_pkg::*; (
  input  frame_state_t          cur,
  input  logic [7:0]            data_byte,
  input  logic [LenW-1:0]       max_len,
  output frame_state_t          nxt,
  output frame_result_t         res
);

  logic [LenW-1:0] grp;
  logic [LenW-1:0] accum_sum;
  logic [LenW-1:0] left_dec;
  logic [OffW-1:0] off_inc;

  assign off_inc  = cur.write_offset + {{(OffW-1){1'b0}}, 1'b1};
  assign left_dec = (cur.data_left != '0) ? cur.data_left - {{(LenW-1){1'b0}}, 1'b1} : '0;

  always_comb begin
    grp = '0;
    unique case (cur.phase)
      PH_LEN0: grp = {21'd0, data_byte[6:0]};
      PH_LEN1: grp = {14'd0, data_byte[6:0], 7'd0};
      PH_LEN2: grp = {7'd0, data_byte[6:0], 14'd0};
      PH_LEN3: grp = {data_byte[6:0], 21'd0};
      default: grp = '0;
    endcase
  end

  assign accum_sum = cur.length_accum + grp;

  always_comb begin
    nxt = cur;
    res.byte_value    = data_byte;
    res.byte_offset   = '0;
    res.packet_start  = 1'b0;
    res.status        = ST_PROGRESS;
    res.packet_length = '0;
    unique case (cur.phase)
      PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3: begin
        res.byte_offset  = cur.write_offset;
        nxt.write_offset = off_inc;
        nxt.length_accum = accum_sum;
        priority if ((data_byte & ContBit) != 8'd0) begin
          if (cur.phase != PH_LEN3) begin
            nxt.phase = phase_t'(cur.phase + 3'd1);
          end else begin
            res.status = ST_MALFORMED;
            nxt.phase  = PH_TYPE;
          end
        end else if (accum_sum > max_len) begin
          res.status = ST_TOO_LONG;
          nxt.phase  = PH_TYPE;
        end else if (accum_sum == '0) begin
          res.status        = ST_COMPLETE;
          res.packet_length = off_inc;
          nxt.phase         = PH_TYPE;
        end else begin
          nxt.data_left = accum_sum;
          nxt.phase     = PH_DATA;
        end
      end
      PH_DATA: begin
        res.byte_offset  = cur.write_offset;
        nxt.write_offset = off_inc;
        nxt.data_left    = left_dec;
        if (left_dec == '0) begin
          res.status        = ST_COMPLETE;
          res.packet_length = off_inc;
          nxt.phase         = PH_TYPE;
        end
      end
      default: begin
        res.packet_start = 1'b1;
        nxt.write_offset = {{(OffW-1){1'b0}}, 1'b1};
        nxt.length_accum = '0;
        nxt.data_left    = '0;
        nxt.phase        = PH_LEN0;
      end
    endcase
  end

endmodule

>>> rtl/mqtt_packet_deframer_unit.sv
// A taken byte is registered and its tags appear on the result port in the next cycle.
// Throughput: one byte per cycle unless the result side stalls, set by the single state update.
// The input is ready whenever the result register is empty or is being taken.
// Reset (rst, synchronous): phase to type byte, counters to zero, limit to 1024, no result held.
// ----------------------------------------------------------------------------
// MQTT packet deframer
// Frames MQTT packets from a byte stream and tags every byte with offset,
// start mark and status.
// ----------------------------------------------------------------------------
module mqtt_packet_deframer_unit import mqttd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [LenW-1:0] cfg_data,
  input  logic            item_valid,
  output logic            item_ready,
  input  logic [7:0]      data_byte,
  output logic            result_valid,
  input  logic            result_ready,
  output logic [7:0]      byte_value,
  output logic [OffW-1:0] byte_offset,
  output logic            packet_start,
  output logic [1:0]      status,
  output logic [OffW-1:0] packet_length
);

  frame_state_t    state;
  frame_state_t    state_next;
  frame_result_t   step_res;
  frame_result_t   result;
  logic [LenW-1:0] max_len;
  logic            take;

  assign cfg_ready  = 1'b1;
  assign item_ready = !result_valid || result_ready;
  assign take       = item_valid && item_ready;

  mqttd_step u_step (
    .cur       (state),
    .data_byte (data_byte),
    .max_len   (max_len),
    .nxt       (state_next),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MaxLenReset;
    end else if (cfg_valid) begin
      max_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= PH_TYPE;
      state.length_accum <= '0;
      state.data_left    <= '0;
      state.write_offset <= '0;
      result_valid       <= 1'b0;
    end else begin
      if (take) begin
        state <= state_next;
      end
      if (take) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= step_res;
    end
  end

  assign byte_value    = result.byte_value;
  assign byte_offset   = result.byte_offset;
  assign packet_start  = result.packet_start;
  assign status        = result.status;
  assign packet_length = result.packet_length;

`ifndef SYNTHESIS
  a_start_offset: assert property (@(posedge clk) disable iff (rst)
    result_valid && packet_start |-> byte_offset == '0 && status == ST_PROGRESS)
    else $error("type byte not at offset zero");

  a_len_complete: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_COMPLETE |->
      packet_length == byte_offset + {{(OffW-1){1'b0}}, 1'b1})
    else $error("packet length does not match last offset");

  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_COMPLETE |-> packet_length == '0)
    else $error("packet length set without completion");

  a_after_end: assert property (@(posedge clk) disable iff (rst)
    take && step_res.status != ST_PROGRESS |=> state.phase == PH_TYPE)
    else $error("packet end did not return to type byte");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    state.phase <= PH_DATA)
    else $error("unused phase code reached");
`endif

endmodule

>>> dv/mqtt_deframe_checker.sv
// ----------------------------------------------------------------------------
// MQTT deframer checker
// Watches the configuration, byte and result channels of the deframer, keeps
// its own copy of the framing state and the length limit, predicts the tags
// of every accepted byte and compares each accepted result, field by field,
// with the oldest prediction still due.
// ----------------------------------------------------------------------------
module mqtt_deframe_checker import mqttd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [LenW-1:0] cfg_data,
  input  logic            item_valid,
  input  logic            item_ready,
  input  logic [7:0]      data_byte,
  input  logic            result_valid,
  input  logic            result_ready,
  input  logic [7:0]      byte_value,
  input  logic [OffW-1:0] byte_offset,
  input  logic            packet_start,
  input  logic [1:0]      status,
  input  logic [OffW-1:0] packet_length,
  output int unsigned     pending,
  output int unsigned     mismatches
);

  timeunit 1ns;
  timeprecision 1ps;

  phase_t          ph;
  logic [LenW-1:0] accum;
  logic [LenW-1:0] left;
  logic [LenW-1:0] limit;
  logic [OffW-1:0] woff;
  frame_result_t   byte_tags_due[$];

  initial begin
    pending = 0;
    mismatches = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  function automatic frame_result_t deframe_byte(input logic [7:0] b);
    frame_result_t   r;
    int              k;
    logic [LenW-1:0] grp;
    r.byte_value    = b;
    r.byte_offset   = '0;
    r.packet_start  = 1'b0;
    r.status        = ST_PROGRESS;
    r.packet_length = '0;
    case (ph)
      PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3: begin
        k = int'(ph) - int'(PH_LEN0);
        r.byte_offset = woff;
        woff = woff + 1'b1;
        grp = LenW'(b[6:0]) << (7 * k);
        accum = accum + grp;
        if ((b & ContBit) != 0) begin
          if (k < 3) begin
            ph = phase_t'(ph + 3'd1);
          end else begin
            r.status = ST_MALFORMED;
            ph = PH_TYPE;
          end
        end else if (accum > limit) begin
          r.status = ST_TOO_LONG;
          ph = PH_TYPE;
        end else if (accum == '0) begin
          r.status = ST_COMPLETE;
          r.packet_length = woff;
          ph = PH_TYPE;
        end else begin
          left = accum;
          ph = PH_DATA;
        end
      end
      PH_DATA: begin
        r.byte_offset = woff;
        woff = woff + 1'b1;
        if (left != '0) left = left - 1'b1;
        if (left == '0) begin
          r.status = ST_COMPLETE;
          r.packet_length = woff;
          ph = PH_TYPE;
        end
      end
      default: begin
        r.packet_start = 1'b1;
        woff = OffW'(1);
        accum = '0;
        left = '0;
        ph = PH_LEN0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      ph = PH_TYPE;
      accum = '0;
      left = '0;
      woff = '0;
      limit = MaxLenReset;
      byte_tags_due.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (byte_tags_due.size() == 0) begin
          report_mismatch("result with no item due, byte_value", 32'(byte_value), 32'd0);
        end else begin
          want = byte_tags_due.pop_front();
          if (byte_value !== want.byte_value)
            report_mismatch("byte_value", 32'(byte_value), 32'(want.byte_value));
          if (byte_offset !== want.byte_offset)
            report_mismatch("byte_offset", 32'(byte_offset), 32'(want.byte_offset));
          if (packet_start !== want.packet_start)
            report_mismatch("packet_start", 32'(packet_start), 32'(want.packet_start));
          if (status !== want.status)
            report_mismatch("status", 32'(status), 32'(want.status));
          if (packet_length !== want.packet_length)
            report_mismatch("packet_length", 32'(packet_length),
                            32'(want.packet_length));
        end
      end
      if (item_valid && item_ready) byte_tags_due.push_back(deframe_byte(data_byte));
      if (cfg_valid && cfg_ready) limit = cfg_data;
    end
    pending = byte_tags_due.size();
  end

endmodule

>>> dv/mqtt_packet_deframer_unit_test.sv
// ----------------------------------------------------------------------------
// MQTT deframer testbench
// Drives byte streams of well-formed, zero-length, too-long and malformed
// packets with some noise through the deframer under a series of length
// limits, with random gaps and stalls on both channels, and gives the verdict
// from the checker's mismatch count, or fails through the quiet-cycle watchdog.
// ----------------------------------------------------------------------------
module mqtt_packet_deframer_unit_test import mqttd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit = 2000;
  localparam logic [LenW-1:0] LenMax = '1;

  logic            clk;
  logic            rst;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [LenW-1:0] cfg_data;
  logic            item_valid;
  logic            item_ready;
  logic [7:0]      data_byte;
  logic            result_valid;
  logic            result_ready;
  logic [7:0]      byte_value;
  logic [OffW-1:0] byte_offset;
  logic            packet_start;
  logic [1:0]      status;
  logic [OffW-1:0] packet_length;
  int unsigned     pending;
  int unsigned     mismatches;
  int unsigned     quiet_cycles;

  mqtt_packet_deframer_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_ready(item_ready), .data_byte(data_byte),
    .result_valid(result_valid), .result_ready(result_ready),
    .byte_value(byte_value), .byte_offset(byte_offset),
    .packet_start(packet_start), .status(status), .packet_length(packet_length)
  );

  mqtt_deframe_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_ready(item_ready), .data_byte(data_byte),
    .result_valid(result_valid), .result_ready(result_ready),
    .byte_value(byte_value), .byte_offset(byte_offset),
    .packet_start(packet_start), .status(status), .packet_length(packet_length),
    .pending(pending), .mismatches(mismatches)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, with stretches of none
  initial begin
    int unsigned gap;
    int unsigned taken;
    bit          steady;
    result_ready = 1'b0;
    taken = 0;
    steady = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (taken % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      gap = steady ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      @(negedge clk);
      taken++;
    end
  end

  task automatic write_limit(input logic [LenW-1:0] value);
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_bytes(ref logic [7:0] q[$]);
    int unsigned gap;
    bit          steady;
    steady = 1'b0;
    foreach (q[i]) begin
      if (i % 32 == 0) steady = ($urandom_range(0, 2) == 0);
      gap = steady ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      item_valid <= 1'b1;
      data_byte  <= q[i];
      @(posedge clk);
      while (!item_ready) @(posedge clk);
      @(negedge clk);
    end
    item_valid <= 1'b0;
  endtask

  task automatic add_packet(ref logic [7:0] q[$], input logic [LenW-1:0] lim);
    int unsigned pick;
    int unsigned len;
    int unsigned nbytes;
    bit          with_data;
    logic [7:0]  grp;
    pick = $urandom_range(0, 11);
    with_data = 1'b1;
    len = 0;
    q.push_back(8'($urandom_range(0, 255)));
    if (pick == 2) begin
      // length field that never ends
      repeat (4) q.push_back(ContBit | 8'($urandom_range(0, 127)));
    end else begin
      if (pick == 0) begin
        len = 0;
      end else if (pick == 1 && lim < LenMax) begin
        len = 32'(lim) + 1;
        if ($urandom_range(0, 1) == 0) len += $urandom % (32'(LenMax) - 32'(lim));
        with_data = 1'b0;
      end else if (pick == 3 && lim <= 300) begin
        len = lim;
      end else if (lim == 0) begin
        len = 0;
      end else begin
        len = $urandom_range(1, (lim < 24) ? 32'(lim) : 24);
      end
      nbytes = 1;
      while (nbytes < 4 && (len >> (7 * nbytes)) != 0) nbytes++;
      if ($urandom_range(0, 3) == 0) nbytes = $urandom_range(nbytes, 4);
      for (int i = 0; i < nbytes; i++) begin
        grp = 8'((len >> (7 * i)) & 32'h7F);
        if (i < nbytes - 1) grp = grp | ContBit;
        q.push_back(grp);
      end
      if (with_data) repeat (len) q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [7:0]      stream[$];
    logic [LenW-1:0] lim;
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    item_valid = 1'b0;
    data_byte  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero length, extremes of data, too long, continuation bit on the fourth length byte,
    // padded length field, largest length
    write_limit(LenW'(3));
    stream = '{8'h00, 8'h00,
               8'hFF, 8'h02, 8'h00, 8'hFF,
               8'h30, 8'h04,
               8'h10, 8'h80, 8'h80, 8'h80, 8'h80,
               8'h20, 8'h83, 8'h80, 8'h00, 8'hAA, 8'h55, 8'h7F,
               8'hF0, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
    send_bytes(stream);

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: lim = '0;
        1: lim = LenW'(127);
        2: lim = LenW'(128);
        3: lim = MaxLenReset;
        4: lim = LenW'(16383);
        5: lim = LenMax;
        6: lim = LenW'($urandom_range(1, 300));
        7: lim = LenW'($urandom);
        default: lim = LenW'(16384);
      endcase
      write_limit(lim);
      stream.delete();
      while (stream.size() < 80) begin
        if (lim <= 300 && $urandom_range(0, 9) == 0)
          stream.push_back(8'($urandom_range(0, 255)));
        add_packet(stream, lim);
      end
      send_bytes(stream);
    end

    while (pending != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> mqtt_packet_deframer_unit.f
rtl/mqttd_pkg.sv
rtl/mqttd_step.sv
rtl/mqtt_packet_deframer_unit.sv
dv/mqtt_deframe_checker.sv
dv/mqtt_packet_deframer_unit_test.sv
